// ===== src/cle_pkg.sv =====
package cle_pkg;

   localparam int LINE_CAPACITY = 256;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [7:0] CH_ETX      = 8'h03;
   localparam logic [7:0] CH_BS       = 8'h08;
   localparam logic [7:0] CH_LF       = 8'h0a;
   localparam logic [7:0] CH_CR       = 8'h0d;
   localparam logic [7:0] CH_ESC      = 8'h1b;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_UP       = 8'h41;
   localparam logic [7:0] CH_RIGHT    = 8'h43;
   localparam logic [7:0] CH_LEFT     = 8'h44;
   localparam logic [7:0] CH_LBRACKET = 8'h5b;

   localparam logic KIND_CONSOLE = 1'b0;
   localparam logic KIND_READ    = 1'b1;

   typedef enum logic [2:0] {
      ESC_NONE    = 3'b001,
      ESC_SEEN    = 3'b010,
      ESC_BRACKET = 3'b100
   } esc_type;

   // One queued job: up to three result words that share kind and length.
   typedef struct packed {
      logic       kind;
      logic [1:0] count;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic       done;
      logic [7:0] len;
   } entry_type;

endpackage

// ===== src/console_line_editor.sv =====
// Channel    Direction  Words per item  Fields
// req_       in         1               kind, in_byte, read_index
// rsp_       out        0 to 3          result_kind, out_byte, last, line_done, line_length
//
// A new request word is taken every cycle unless the front stage holds a job and the job queue is full.
// The output side sends one word per cycle while rsp_ready is high; an item with k results takes k words.
// The first result of a request passes the front stage, the queue and the output register, in that order.
// Reset is synchronous; the line store itself is not cleared and needs no sweep.
// A stalled rsp_ side fills the queue, then req_ready drops.
module console_line_editor #(
   parameter int LINE_CAPACITY = cle_pkg::LINE_CAPACITY
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_in_byte,
   input  logic [7:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_result_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   output logic       rsp_line_done,
   output logic [7:0] rsp_line_length
);

   logic               push_valid, push_ready, pop_valid, pop_ready;
   cle_pkg::entry_type push_entry, pop_entry;

   cle_front #(.LineCapacity(LINE_CAPACITY)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_in_byte    (req_in_byte),
      .req_read_index (req_read_index),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_entry     (push_entry)
   );

   cle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   cle_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_entry       (pop_entry),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last),
      .rsp_line_done   (rsp_line_done),
      .rsp_line_length (rsp_line_length)
   );

endmodule

// ===== src/cle_front.sv =====
module cle_front #(
   parameter int LineCapacity = cle_pkg::LINE_CAPACITY
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [7:0]          req_in_byte,
   input  logic [7:0]          req_read_index,
   output logic                push_valid,
   input  logic                push_ready,
   output cle_pkg::entry_type  push_entry
);

   localparam int CW = $clog2(LineCapacity);
   localparam int LW = (CW > 8) ? CW : 8;
   localparam logic [CW-1:0] FullMark = CW'(LineCapacity - 1);

   logic [7:0]          mem [LineCapacity];
   logic [7:0]          rd_ff;

   logic [CW-1:0]       fill_ff, fill_in;
   logic [CW-1:0]       cursor_ff, cursor_in;
   cle_pkg::esc_type    esc_ff, esc_in;
   logic                ready_ff, ready_in;

   logic                p1_valid_ff;
   cle_pkg::entry_type  p1_ent_ff, ent;
   logic                p1_mem_ff, use_mem;

   logic                accept, has_res, wr_en, rd_en;
   logic [CW-1:0]       rd_addr, fill_eff, cur_eff;
   logic [LW-1:0]       idx_wide, fill_wide, len_wide;
   logic [7:0]          b;

   assign accept    = req_valid && req_ready;
   assign req_ready = !p1_valid_ff || push_ready;
   assign b         = req_in_byte;
   assign fill_eff  = ready_ff ? '0 : fill_ff;
   assign cur_eff   = ready_ff ? '0 : cursor_ff;
   assign idx_wide  = LW'(req_read_index);
   assign fill_wide = LW'(fill_ff);
   assign len_wide  = LW'(fill_in);

   always_comb begin
      fill_in   = fill_ff;
      cursor_in = cursor_ff;
      esc_in    = esc_ff;
      ready_in  = ready_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = cur_eff;
      use_mem   = 1'b0;
      has_res   = 1'b0;
      ent       = '0;
      if (req_kind == cle_pkg::KIND_READ) begin
         has_res   = 1'b1;
         ent.kind  = cle_pkg::KIND_READ;
         ent.count = 2'd1;
         if (idx_wide < fill_wide) begin
            rd_en   = 1'b1;
            rd_addr = idx_wide[CW-1:0];
            use_mem = 1'b1;
         end
      end else begin
         // a new line starts on the first byte after the previous one ended
         ready_in  = 1'b0;
         fill_in   = fill_eff;
         cursor_in = cur_eff;
         if (b == cle_pkg::CH_ESC) begin
            esc_in = cle_pkg::ESC_SEEN;
         end else if (esc_ff == cle_pkg::ESC_SEEN && b == cle_pkg::CH_LBRACKET) begin
            esc_in = cle_pkg::ESC_BRACKET;
         end else if (esc_ff == cle_pkg::ESC_BRACKET && b >= cle_pkg::CH_UP &&
                      b <= cle_pkg::CH_LEFT) begin
            esc_in = cle_pkg::ESC_NONE;
            if (b == cle_pkg::CH_RIGHT && cur_eff < fill_eff) begin
               rd_en     = 1'b1;
               use_mem   = 1'b1;
               has_res   = 1'b1;
               ent.count = 2'd1;
               cursor_in = CW'(cur_eff + 1'b1);
            end else if (b == cle_pkg::CH_LEFT && cur_eff != '0) begin
               has_res   = 1'b1;
               ent.count = 2'd1;
               ent.b0    = cle_pkg::CH_BS;
               cursor_in = CW'(cur_eff - 1'b1);
            end
         end else begin
            esc_in = cle_pkg::ESC_NONE;
            if (b == cle_pkg::CH_CR || b == cle_pkg::CH_LF) begin
               cursor_in = '0;
               ready_in  = 1'b1;
               has_res   = 1'b1;
               ent.count = 2'd2;
               ent.b0    = cle_pkg::CH_CR;
               ent.b1    = cle_pkg::CH_LF;
               ent.done  = 1'b1;
            end else if (b == cle_pkg::CH_BS) begin
               if (fill_eff != '0) begin
                  fill_in   = CW'(fill_eff - 1'b1);
                  cursor_in = CW'(fill_eff - 1'b1);
                  has_res   = 1'b1;
                  ent.count = 2'd3;
                  ent.b0    = cle_pkg::CH_BS;
                  ent.b1    = cle_pkg::CH_SPACE;
                  ent.b2    = cle_pkg::CH_BS;
               end
            end else if (b == cle_pkg::CH_ETX) begin
               fill_in   = '0;
               cursor_in = '0;
               ready_in  = 1'b1;
               has_res   = 1'b1;
               ent.count = 2'd2;
               ent.b0    = cle_pkg::CH_LF;
               ent.b1    = cle_pkg::CH_CR;
               ent.done  = 1'b1;
            end else if (fill_eff < FullMark) begin
               wr_en     = 1'b1;
               fill_in   = CW'(fill_eff + 1'b1);
               cursor_in = CW'(fill_eff + 1'b1);
               has_res   = 1'b1;
               ent.count = 2'd1;
               ent.b0    = b;
            end
         end
      end
      ent.len = len_wide[7:0];
   end

   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         mem[fill_eff] <= b;
      end
      if (accept && rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         cursor_ff   <= '0;
         esc_ff      <= cle_pkg::ESC_NONE;
         ready_ff    <= 1'b0;
         p1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            fill_ff   <= fill_in;
            cursor_ff <= cursor_in;
            esc_ff    <= esc_in;
            ready_ff  <= ready_in;
         end
         if (req_ready) begin
            p1_valid_ff <= accept && has_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_ent_ff <= ent;
         p1_mem_ff <= use_mem;
      end
   end

   // merge the store read that was issued on accept
   always_comb begin
      push_entry = p1_ent_ff;
      if (p1_mem_ff) begin
         push_entry.b0 = rd_ff;
      end
   end

   assign push_valid = p1_valid_ff;

endmodule

// ===== src/cle_queue.sv =====
module cle_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  cle_pkg::entry_type  push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output cle_pkg::entry_type  pop_entry
);

   localparam int Depth = cle_pkg::QUEUE_DEPTH;
   localparam int PW    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int NW    = $clog2(Depth + 1);

   cle_pkg::entry_type slots [Depth];
   logic [PW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]      count_ff;
   logic               do_push, do_pop;

   assign push_ready = count_ff != NW'(Depth);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slots[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(Depth - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(Depth - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
         end
         if (do_push && !do_pop) begin
            count_ff <= NW'(count_ff + 1'b1);
         end else if (do_pop && !do_push) begin
            count_ff <= NW'(count_ff - 1'b1);
         end
      end
   end

endmodule

// ===== src/cle_back.sv =====
module cle_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  cle_pkg::entry_type  pop_entry,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_result_kind,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last,
   output logic                rsp_line_done,
   output logic [7:0]          rsp_line_length
);

   cle_pkg::entry_type cur_ff;
   logic               valid_ff;
   logic [1:0]         idx_ff;

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = cur_ff.kind;
   assign rsp_line_length = cur_ff.len;
   assign rsp_last        = idx_ff == 2'(cur_ff.count - 1'b1);
   assign rsp_line_done   = cur_ff.done && rsp_last;
   assign pop_ready       = !valid_ff || (rsp_ready && rsp_last);

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_out_byte = cur_ff.b0;
         2'd1:    rsp_out_byte = cur_ff.b1;
         default: rsp_out_byte = cur_ff.b2;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (pop_ready) begin
         valid_ff <= pop_valid;
         idx_ff   <= '0;
      end else if (rsp_ready) begin
         // advance to the next word of the same job
         idx_ff <= 2'(idx_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         cur_ff <= pop_entry;
      end
   end

endmodule

// ===== src/cle_checker.sv =====
module cle_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_result_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last,
   input logic       rsp_line_done,
   input logic [7:0] rsp_line_length
);

   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_last) && $stable(rsp_result_kind) && $stable(rsp_line_length))
      else $error("rsp word changed while stalled");

   a_read_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |-> rsp_last && !rsp_line_done)
      else $error("read data must be a single word without line_done");

   a_done_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_done |-> rsp_last && !rsp_result_kind)
      else $error("line_done only on the last echo word");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid right after reset");

endmodule

bind console_line_editor cle_checker u_cle_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_kind (rsp_result_kind),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last        (rsp_last),
   .rsp_line_done   (rsp_line_done),
   .rsp_line_length (rsp_line_length)
);
